// File: rtl/packet_header_parser_checksum_top_macros.svh
// Assertion helpers for the checker in php_checker.sv
`ifndef PACKET_HEADER_PARSER_CHECKSUM_TOP_MACROS_SVH
`define PACKET_HEADER_PARSER_CHECKSUM_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define PHP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent in the next cycle
`define PHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/php_pkg.sv
`default_nettype none
package php_pkg;
    localparam logic [15:0] MAX_FRAME_BYTES = 16'd16383;
    localparam logic [15:0] ETH_LEN   = 16'd14;
    localparam logic [15:0] TYPE_IPV4 = 16'd2048;
    localparam logic [15:0] TYPE_ARP  = 16'd2054;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam int          MAX_RES = 3;

    localparam logic [4:0] K_DST_MAC = 5'd0;
    localparam logic [4:0] K_SRC_MAC = 5'd1;
    localparam logic [4:0] K_ETYPE   = 5'd2;
    localparam logic [4:0] K_IHL     = 5'd3;
    localparam logic [4:0] K_TOS     = 5'd4;
    localparam logic [4:0] K_TOTLEN  = 5'd5;
    localparam logic [4:0] K_TTL     = 5'd6;
    localparam logic [4:0] K_PROTO   = 5'd7;
    localparam logic [4:0] K_IPCSUM  = 5'd8;
    localparam logic [4:0] K_IPSRC   = 5'd9;
    localparam logic [4:0] K_IPDST   = 5'd10;
    localparam logic [4:0] K_ARP_OP  = 5'd11;
    localparam logic [4:0] K_ARP_SHA = 5'd12;
    localparam logic [4:0] K_ARP_SPA = 5'd13;
    localparam logic [4:0] K_ARP_THA = 5'd14;
    localparam logic [4:0] K_ARP_TPA = 5'd15;
    localparam logic [4:0] K_ICMP    = 5'd16;
    localparam logic [4:0] K_SPORT   = 5'd17;
    localparam logic [4:0] K_DPORT   = 5'd18;
    localparam logic [4:0] K_SEQ     = 5'd19;
    localparam logic [4:0] K_ACK     = 5'd20;
    localparam logic [4:0] K_FLAGS   = 5'd21;
    localparam logic [4:0] K_WIN     = 5'd22;
    localparam logic [4:0] K_TCPCSUM = 5'd23;
    localparam logic [4:0] K_FLEN    = 5'd24;

    typedef struct packed {
        logic [4:0]  kind;
        logic [47:0] value;
        logic        last;
    } res_t;

    // ones-complement add, folded to 16 bits
    function automatic logic [15:0] add16(input logic [15:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'd0, t[16]};
    endfunction
endpackage
`default_nettype wire

// File: rtl/php_out_queue.sv
`default_nettype none
// Holds up to one byte's worth of results (three) plus drains them one per cycle when stall is low.
// Takes a new group only when empty or when the last held result leaves.
module php_out_queue
    import php_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [1:0]  load_cnt,
    input  res_t             load_res [MAX_RES],
    output logic             can_load,
    output logic             valid,
    input  wire logic        stall,
    output res_t             head
);
    res_t       buf_reg [MAX_RES];
    logic [1:0] cnt_reg;
    logic [1:0] rd_reg;
    logic       pop;

    assign valid    = (cnt_reg != 2'd0);
    assign pop      = valid && !stall;
    assign can_load = !valid || (pop && (rd_reg + 2'd1 == cnt_reg));
    assign head     = buf_reg[rd_reg];

    // group buffer
    always_ff @(posedge clk) begin
        if (load && can_load) begin
            buf_reg <= load_res;
        end
    end

    // fill count and read pointer
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else if (load && can_load) begin
            cnt_reg <= load_cnt;
            rd_reg  <= 2'd0;
        end
        else if (pop) begin
            if (rd_reg + 2'd1 == cnt_reg) begin
                cnt_reg <= 2'd0;
                rd_reg  <= 2'd0;
            end
            else begin
                rd_reg <= rd_reg + 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/packet_header_parser_checksum_top.sv
// A byte's first result is loaded into the result queue as the byte is taken and shown in the next cycle.
// Throughput: one byte per cycle while each byte yields at most one result and out_stall
// is low; after a byte with several results the input stalls until they drain (one a cycle while not stalled).
// Reset: rst_n clears all parse state and the result queue asynchronously;
// parse state is also cleared after every last byte.
`default_nettype none
module packet_header_parser_checksum_top
    import php_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       field_kind,
    output logic [47:0]      field_value,
    output logic             frame_end
);
    logic [15:0] pos_reg;
    logic [47:0] shift_reg;
    logic [15:0] ekind_reg;
    logic [5:0]  ihl_reg;
    logic [15:0] tlen_reg;
    logic [7:0]  proto_reg;
    logic [15:0] ipsum_reg;
    logic [15:0] tcpsum_reg;

    logic [15:0] pos_next, ekind_next, tlen_next, ipsum_next, tcpsum_next;
    logic [47:0] shift_next;
    logic [5:0]  ihl_next;
    logic [7:0]  proto_next;

    res_t       res [MAX_RES];
    logic [1:0] n;
    logic       can_load, take;
    res_t       head;

    assign in_stall = !can_load;
    assign take     = in_valid && can_load;

    // parse one byte
    always_comb begin
        logic [15:0] p, q, t, s, raw;
        logic [47:0] fs;
        logic        act, isip, isarp, is_tcp, is_udp;
        logic [5:0]  hl;
        pos_next = pos_reg; shift_next = shift_reg; ekind_next = ekind_reg;
        ihl_next = ihl_reg; tlen_next = tlen_reg; proto_next = proto_reg;
        ipsum_next = ipsum_reg; tcpsum_next = tcpsum_reg;
        n = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end
        p = pos_reg;
        act = (pos_reg < MAX_FRAME_BYTES);
        fs = {shift_reg[39:0], frame_byte};
        q = p - ETH_LEN;
        raw = {8'd0, 2'd0, frame_byte[3:0], 2'd0};
        isip = act && (p >= ETH_LEN) && (ekind_reg == TYPE_IPV4);
        isarp = act && (p >= ETH_LEN) && (ekind_reg == TYPE_ARP);
        hl = (isip && q == 16'd0) ? ((raw < 16'd20) ? 6'd20 : raw[5:0]) : ihl_reg;
        t = q - {10'd0, hl};
        s = 16'd0;
        if (act) begin
            pos_next = p + 16'd1;
            shift_next = fs;
            if (p == 16'd5) begin
                res[n] = '{K_DST_MAC, fs, 1'b0}; n = n + 2'd1;
            end
            else if (p == 16'd11) begin
                res[n] = '{K_SRC_MAC, fs, 1'b0}; n = n + 2'd1;
            end
            else if (p == 16'd13) begin
                ekind_next = fs[15:0];
                res[n] = '{K_ETYPE, {32'd0, fs[15:0]}, 1'b0}; n = n + 2'd1;
            end
        end
        if (isip) begin
            if (q == 16'd0) begin
                ihl_next = hl;
                res[n] = '{K_IHL, {32'd0, raw}, 1'b0}; n = n + 2'd1;
            end
            s = q[0] ? {8'd0, frame_byte} : {frame_byte, 8'd0};
            if (q < {10'd0, hl}) ipsum_next = add16(ipsum_reg, s);
            if (q >= 16'd12 && q < 16'd20) tcpsum_next = add16(tcpsum_reg, s);
            case (q)
                16'd1: begin res[n] = '{K_TOS, {40'd0, frame_byte}, 1'b0}; n = n + 2'd1; end
                16'd3: begin
                    tlen_next = fs[15:0];
                    res[n] = '{K_TOTLEN, {32'd0, fs[15:0]}, 1'b0}; n = n + 2'd1;
                end
                16'd8: begin res[n] = '{K_TTL, {40'd0, frame_byte}, 1'b0}; n = n + 2'd1; end
                16'd9: begin
                    proto_next = frame_byte;
                    res[n] = '{K_PROTO, {40'd0, frame_byte}, 1'b0}; n = n + 2'd1;
                end
                16'd15: begin res[n] = '{K_IPSRC, {16'd0, fs[31:0]}, 1'b0}; n = n + 2'd1; end
                16'd19: begin res[n] = '{K_IPDST, {16'd0, fs[31:0]}, 1'b0}; n = n + 2'd1; end
                default: ;
            endcase
            if (q + 16'd1 == {10'd0, hl}) begin
                res[n] = '{K_IPCSUM, {47'd0, ipsum_next == 16'hFFFF}, 1'b0}; n = n + 2'd1;
            end
            is_tcp = (proto_next == PROTO_TCP);
            is_udp = (proto_next == PROTO_UDP);
            if (q >= {10'd0, hl}) begin
                if (is_tcp && q < tlen_next) begin
                    tcpsum_next = add16(tcpsum_reg, t[0] ? {8'd0, frame_byte}
                                                         : {frame_byte, 8'd0});
                end
                if (proto_next == PROTO_ICMP && t == 16'd0) begin
                    res[n] = '{K_ICMP, {40'd0, frame_byte}, 1'b0}; n = n + 2'd1;
                end
                if ((is_tcp || is_udp) && t == 16'd1) begin
                    res[n] = '{K_SPORT, {32'd0, fs[15:0]}, 1'b0}; n = n + 2'd1;
                end
                if ((is_tcp || is_udp) && t == 16'd3) begin
                    res[n] = '{K_DPORT, {32'd0, fs[15:0]}, 1'b0}; n = n + 2'd1;
                end
                if (is_tcp && t == 16'd7) begin
                    res[n] = '{K_SEQ, {16'd0, fs[31:0]}, 1'b0}; n = n + 2'd1;
                end
                if (is_tcp && t == 16'd13) begin
                    if (frame_byte[4]) begin
                        res[n] = '{K_ACK, {16'd0, fs[47:16]}, 1'b0}; n = n + 2'd1;
                    end
                    res[n] = '{K_FLAGS, {40'd0, frame_byte}, 1'b0}; n = n + 2'd1;
                end
                if (is_tcp && t == 16'd15) begin
                    res[n] = '{K_WIN, {32'd0, fs[15:0]}, 1'b0}; n = n + 2'd1;
                end
            end
        end
        if (isarp) begin
            case (q)
                16'd7:  begin res[n] = '{K_ARP_OP, {40'd0, frame_byte}, 1'b0}; n = n + 2'd1; end
                16'd13: begin res[n] = '{K_ARP_SHA, fs, 1'b0}; n = n + 2'd1; end
                16'd17: begin res[n] = '{K_ARP_SPA, {16'd0, fs[31:0]}, 1'b0}; n = n + 2'd1; end
                16'd23: begin res[n] = '{K_ARP_THA, fs, 1'b0}; n = n + 2'd1; end
                16'd27: begin res[n] = '{K_ARP_TPA, {16'd0, fs[31:0]}, 1'b0}; n = n + 2'd1; end
                default: ;
            endcase
        end
        // frame end: TCP verdict and length
        if (last_byte) begin
            if (ekind_next == TYPE_IPV4 && proto_next == PROTO_TCP
                && pos_next >= 16'd34 + {10'd0, ihl_next}) begin
                s = add16(add16(tcpsum_next, {8'd0, proto_next}),
                          tlen_next - {10'd0, ihl_next});
                res[n] = '{K_TCPCSUM, {47'd0, s == 16'hFFFF}, 1'b0}; n = n + 2'd1;
            end
            res[n] = '{K_FLEN, {32'd0, pos_next}, 1'b1}; n = n + 2'd1;
            pos_next = '0; shift_next = '0; ekind_next = '0; ihl_next = '0;
            tlen_next = '0; proto_next = '0; ipsum_next = '0; tcpsum_next = '0;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg <= '0; shift_reg <= '0; ekind_reg <= '0; ihl_reg <= '0;
            tlen_reg <= '0; proto_reg <= '0; ipsum_reg <= '0; tcpsum_reg <= '0;
        end
        else if (take) begin
            pos_reg <= pos_next; shift_reg <= shift_next; ekind_reg <= ekind_next;
            ihl_reg <= ihl_next; tlen_reg <= tlen_next; proto_reg <= proto_next;
            ipsum_reg <= ipsum_next; tcpsum_reg <= tcpsum_next;
        end
    end

    php_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_valid && n != 2'd0),
        .load_cnt (n),
        .load_res (res),
        .can_load (can_load),
        .valid    (out_valid),
        .stall    (out_stall),
        .head     (head)
    );

    assign field_kind  = head.kind;
    assign field_value = head.value;
    assign frame_end   = head.last;
endmodule
`default_nettype wire

// File: rtl/php_checker.sv
`default_nettype none
`include "packet_header_parser_checksum_top_macros.svh"
// Port-level checks on the result stream
module php_checker
    import php_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [4:0]  field_kind,
    input wire logic [47:0] field_value,
    input wire logic        frame_end
);
    `PHP_ASSERT_IMPL(a_end_is_len, out_valid && frame_end, field_kind == K_FLEN, "end flag")
    `PHP_ASSERT_IMPL(a_len_is_end, out_valid && field_kind == K_FLEN, frame_end, "no end flag")
    `PHP_ASSERT_IMPL(a_kind_range, out_valid, field_kind <= K_FLEN, "bad field kind")
    `PHP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(field_value), "moved")
endmodule

bind packet_header_parser_checksum_top php_checker u_php_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .field_kind(field_kind), .field_value(field_value), .frame_end(frame_end)
);
`default_nettype wire

// File: tb/sv/packet_header_parser_checksum_checker.sv
module packet_header_parser_checksum_checker
    import php_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [4:0]  field_kind,
    input  logic [47:0] field_value,
    input  logic        frame_end,
    output int          mismatch_count,
    output int          fields_pending
);
    // parser state mirror
    logic [15:0] pos;
    logic [47:0] shreg;
    logic [15:0] etype;
    logic [5:0]  hdr_len;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [15:0] ip_acc;
    logic [15:0] seg_acc;

    res_t field_queue[$];

    assign fields_pending = field_queue.size();

    function automatic logic [15:0] ones_add(logic [15:0] s, logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic logic [15:0] add_byte(logic [15:0] s, logic [15:0] off,
                                             logic [7:0] b);
        return ones_add(s, off[0] ? {8'd0, b} : {b, 8'd0});
    endfunction

    task automatic push_field(logic [4:0] k, logic [47:0] v, logic e);
        res_t r;
        r.kind = k;
        r.value = v;
        r.last = e;
        field_queue.push_back(r);
    endtask

    task automatic clear_state();
        pos = '0;
        shreg = '0;
        etype = '0;
        hdr_len = '0;
        tot_len = '0;
        proto = '0;
        ip_acc = '0;
        seg_acc = '0;
    endtask

    // IPv4 and transport fields, q counted from the IP header start
    task automatic decode_ip(logic [15:0] q, logic [7:0] b);
        logic [5:0]  raw;
        logic [15:0] t;
        if (q == 0)
        begin
            raw = {b[3:0], 2'b00};
            hdr_len = (raw < 6'd20) ? 6'd20 : raw;
            push_field(K_IHL, {42'd0, raw}, 1'b0);
        end
        if (q < hdr_len)
            ip_acc = add_byte(ip_acc, q, b);
        if (q >= 12 && q < 20)
            seg_acc = add_byte(seg_acc, q, b);
        case (q)
            16'd1: push_field(K_TOS, {40'd0, b}, 1'b0);
            16'd3:
            begin
                tot_len = shreg[15:0];
                push_field(K_TOTLEN, {32'd0, tot_len}, 1'b0);
            end
            16'd8: push_field(K_TTL, {40'd0, b}, 1'b0);
            16'd9:
            begin
                proto = b;
                push_field(K_PROTO, {40'd0, b}, 1'b0);
            end
            16'd15: push_field(K_IPSRC, {16'd0, shreg[31:0]}, 1'b0);
            16'd19: push_field(K_IPDST, {16'd0, shreg[31:0]}, 1'b0);
            default: ;
        endcase
        if (q + 16'd1 == {10'd0, hdr_len})
            push_field(K_IPCSUM, {47'd0, ip_acc == 16'hFFFF}, 1'b0);
        if (q >= hdr_len)
        begin
            t = q - hdr_len;
            if (proto == PROTO_TCP && q < tot_len)
                seg_acc = add_byte(seg_acc, t, b);
            if (proto == PROTO_ICMP && t == 0)
                push_field(K_ICMP, {40'd0, b}, 1'b0);
            if (proto == PROTO_UDP || proto == PROTO_TCP)
            begin
                if (t == 1) push_field(K_SPORT, {32'd0, shreg[15:0]}, 1'b0);
                if (t == 3) push_field(K_DPORT, {32'd0, shreg[15:0]}, 1'b0);
            end
            if (proto == PROTO_TCP)
            begin
                if (t == 7) push_field(K_SEQ, {16'd0, shreg[31:0]}, 1'b0);
                if (t == 13)
                begin
                    if (b[4]) push_field(K_ACK, {16'd0, shreg[47:16]}, 1'b0);
                    push_field(K_FLAGS, {40'd0, b}, 1'b0);
                end
                if (t == 15) push_field(K_WIN, {32'd0, shreg[15:0]}, 1'b0);
            end
        end
    endtask

    task automatic decode_arp(logic [15:0] q, logic [7:0] b);
        case (q)
            16'd7:  push_field(K_ARP_OP, {40'd0, b}, 1'b0);
            16'd13: push_field(K_ARP_SHA, shreg, 1'b0);
            16'd17: push_field(K_ARP_SPA, {16'd0, shreg[31:0]}, 1'b0);
            16'd23: push_field(K_ARP_THA, shreg, 1'b0);
            16'd27: push_field(K_ARP_TPA, {16'd0, shreg[31:0]}, 1'b0);
            default: ;
        endcase
    endtask

    task automatic predict_byte(logic [7:0] b, logic fin);
        logic [15:0] p;
        logic [15:0] s;
        if (pos < MAX_FRAME_BYTES)
        begin
            p = pos;
            pos = p + 16'd1;
            shreg = {shreg[39:0], b};
            if (p == 5)
                push_field(K_DST_MAC, shreg, 1'b0);
            else if (p == 11)
                push_field(K_SRC_MAC, shreg, 1'b0);
            else if (p == 13)
            begin
                etype = shreg[15:0];
                push_field(K_ETYPE, {32'd0, etype}, 1'b0);
            end
            else if (p >= ETH_LEN)
            begin
                if (etype == TYPE_IPV4)
                    decode_ip(p - ETH_LEN, b);
                else if (etype == TYPE_ARP)
                    decode_arp(p - ETH_LEN, b);
            end
        end
        if (fin)
        begin
            if (etype == TYPE_IPV4 && proto == PROTO_TCP &&
                pos >= ETH_LEN + 16'd20 + hdr_len)
            begin
                s = ones_add(seg_acc, {8'd0, proto});
                s = ones_add(s, tot_len - {10'd0, hdr_len});
                push_field(K_TCPCSUM, {47'd0, s == 16'hFFFF}, 1'b0);
            end
            push_field(K_FLEN, {32'd0, pos}, 1'b1);
            clear_state();
        end
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            clear_state();
            field_queue.delete();
            mismatch_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_byte(frame_byte, last_byte);
            if (out_valid && !out_stall)
            begin
                if (field_queue.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected field: kind %0d value %h end %0b",
                                 field_kind, field_value, frame_end);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = field_queue.pop_front();
                    if (want.kind !== field_kind || want.value !== field_value ||
                        want.last !== frame_end)
                    begin
                        if (mismatch_count < 10)
                            $display("field mismatch: exp %0d/%h/%0b got %0d/%h/%0b",
                                     want.kind, want.value, want.last,
                                     field_kind, field_value, frame_end);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_packet_header_parser_checksum_top.sv
module tb_packet_header_parser_checksum_top;
    import php_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  frame_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  field_kind;
    logic [47:0] field_value;
    logic        frame_end;
    int          mismatch_count;
    int          fields_pending;

    // idle and stall percentages, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;
    int sent = 0;

    logic [7:0] frame_buf[$];

    always #1 clk = ~clk;

    packet_header_parser_checksum_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .frame_byte(frame_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .field_kind(field_kind), .field_value(field_value), .frame_end(frame_end)
    );

    packet_header_parser_checksum_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .frame_byte(frame_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .field_kind(field_kind), .field_value(field_value), .frame_end(frame_end),
        .mismatch_count(mismatch_count), .fields_pending(fields_pending)
    );

    // receiver stall
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic put16(logic [15:0] v);
        frame_buf.push_back(v[15:8]);
        frame_buf.push_back(v[7:0]);
    endtask

    task automatic put_rand(int n);
        repeat (n) frame_buf.push_back(8'($urandom));
    endtask

    // offer each buffered byte, last marked on the final one
    task automatic send_frame();
        int n;
        n = frame_buf.size();
        for (int i = 0; i < n; i++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            frame_byte <= frame_buf[i];
            last_byte <= (i == n - 1);
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
        sent += n;
        frame_buf.delete();
    endtask

    // ones-complement sum of bytes as 16 bit words
    function automatic logic [15:0] csum_of(int first, int cnt, logic [15:0] seed);
        logic [16:0] s;
        logic [15:0] w;
        s = {1'b0, seed};
        for (int i = 0; i < cnt; i += 2)
        begin
            w = {frame_buf[first + i], (i + 1 < cnt) ? frame_buf[first + i + 1] : 8'd0};
            s = s[15:0] + w + s[16];
            s = s[15:0] + s[16];
        end
        return s[15:0];
    endfunction

    // build a frame: kind 0 ipv4, 1 arp, 2 other type; good sums when good is set
    task automatic build_frame(int kind, logic [7:0] pr, int ihl, int payload,
                               bit good, logic [7:0] flags, int trunc, int pad);
        int hl;
        int tl;
        int tstart;
        logic [15:0] s;
        put_rand(12);
        if (kind == 0)
        begin
            put16(TYPE_IPV4);
            hl = (ihl < 5 ? 5 : ihl) * 4;
            tl = hl + ((pr == PROTO_TCP) ? 20 : 8) + payload;
            frame_buf.push_back({4'h4, 4'(ihl)});
            put_rand(1);
            put16(16'(tl));
            put_rand(4);
            frame_buf.push_back(8'($urandom_range(1, 255)));
            frame_buf.push_back(pr);
            put16(16'h0);
            put_rand(hl - 12);
            if (good)
            begin
                s = csum_of(14, hl, 16'h0);
                frame_buf[24] = ~s[15:8];
                frame_buf[25] = ~s[7:0];
            end
            tstart = 14 + hl;
            if (pr == PROTO_TCP)
            begin
                put_rand(12);
                frame_buf.push_back(8'($urandom_range(5, 15)) << 4);
                frame_buf.push_back(flags);
                put_rand(2);
                put16(16'h0);
                put_rand(2);
                put_rand(payload);
                if (good)
                begin
                    s = csum_of(26, 8, 16'h0);
                    s = csum_of(tstart, tl - hl, s);
                    s = csum_of(0, 0, s) + 16'h0;
                    begin
                        logic [16:0] t;
                        t = {1'b0, s} + 17'd6;
                        t = t[15:0] + t[16];
                        t = {1'b0, t[15:0]} + 17'(tl - hl);
                        t = t[15:0] + t[16];
                        frame_buf[tstart + 16] = ~t[15:8];
                        frame_buf[tstart + 17] = ~t[7:0];
                    end
                end
            end
            else
                put_rand(8 + payload);
        end
        else if (kind == 1)
        begin
            put16(TYPE_ARP);
            put_rand(28);
        end
        else
        begin
            put16(16'($urandom));
            put_rand(payload);
        end
        put_rand(pad);
        while (trunc > 0 && frame_buf.size() > 1)
        begin
            void'(frame_buf.pop_back());
            trunc--;
        end
    endtask

    task automatic random_frame();
        int r;
        logic [7:0] pr;
        r = $urandom_range(99);
        pr = (r < 45) ? PROTO_TCP : (r < 65) ? PROTO_UDP : (r < 75) ? PROTO_ICMP
             : 8'($urandom);
        r = $urandom_range(99);
        if (r < 75)
            build_frame(0, pr, ($urandom_range(9) == 0) ? $urandom_range(15) : 5
                        + $urandom_range(1), $urandom_range(6), $urandom_range(5) != 0,
                        8'($urandom), ($urandom_range(7) == 0) ? $urandom_range(40) : 0,
                        ($urandom_range(3) == 0) ? $urandom_range(6) : 0);
        else if (r < 88)
            build_frame(1, 0, 5, 0, 1, 0, ($urandom_range(5) == 0) ? $urandom_range(20)
                        : 0, $urandom_range(4));
        else if (r < 96)
            build_frame(2, 0, 5, $urandom_range(10), 1, 0, 0, 0);
        else
            put_rand($urandom_range(1, 16));
        send_frame();
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (fields_pending != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, ARP, short header, ack set and clear, bad sums
        put_rand(1);
        send_frame();
        frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00);
        send_frame();
        build_frame(0, PROTO_TCP, 5, 4, 1, 8'h10, 0, 0);
        send_frame();
        build_frame(0, PROTO_TCP, 6, 3, 0, 8'hEF, 0, 3);
        send_frame();
        build_frame(0, PROTO_TCP, 2, 0, 1, 8'hFF, 0, 0);
        send_frame();
        build_frame(0, PROTO_UDP, 15, 0, 1, 0, 0, 0);
        send_frame();
        build_frame(0, PROTO_ICMP, 5, 2, 1, 0, 0, 0);
        send_frame();
        build_frame(1, 0, 5, 0, 1, 0, 0, 0);
        send_frame();
        build_frame(0, PROTO_TCP, 5, 0, 1, 8'h10, 25, 0);
        send_frame();
        build_frame(2, 0, 5, 4, 1, 0, 0, 0);
        send_frame();
        drain();

        // random phases with varied idling
        for (int ph = 1; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 66 : (ph == 3) ? 10 : 0;
            recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 10 : 0;
            if (ph == 2)
            begin
                // long receiver hold-off while bytes keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (100) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            sent = 0;
            while (sent < 40)
                random_frame();
            drain();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
